@@ sv/jmcm_pkg.sv @@
// Shared types, constants and helpers for the joystick motor command mixer.
// No dependencies; every other file uses this package.
package jmcm_pkg;

	localparam int AxisW    = 12;
	localparam int DzW      = 8;
	localparam int FanW     = 11;
	localparam int StepW    = 6;
	localparam int PinW     = 2;
	localparam int PwmW     = 8;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 11;

	// H-bridge pin codes
	localparam logic [PinW-1:0] PIN_BACK  = 2'd1;
	localparam logic [PinW-1:0] PIN_FWD   = 2'd2;
	localparam logic [PinW-1:0] PIN_BRAKE = 2'd3;

	// Register indexes
	localparam logic [CfgIdxW-1:0] CFG_DEADZONE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_EDF_MIN  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_EDF_MAX  = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_EDF_STEP = 2'd3;

	localparam logic [DzW-1:0]   DEADZONE_RST = 8'd100;
	localparam logic [FanW-1:0]  EDF_MIN_RST  = 11'd1100;
	localparam logic [FanW-1:0]  EDF_MAX_RST  = 11'd1900;
	localparam logic [StepW-1:0] EDF_STEP_RST = 6'd3;

	localparam logic [AxisW-1:0] FAN_UP_BELOW = 12'd175;
	localparam logic [AxisW-1:0] FAN_DOWN_AT  = 12'd4095;

	// (x*510)/4095 == (x*34)/273; divide by 273 as multiply by ceil(2^26/273)
	localparam logic [5:0]  AXIS_MUL    = 6'd34;
	localparam logic [17:0] AXIS_RECIP  = 18'd245821;
	localparam int          RecipShift  = 26;
	localparam logic [8:0]  AXIS_CENTER = 9'd255;

	typedef struct packed {
		logic [DzW-1:0]   deadzone;
		logic [FanW-1:0]  edf_min_us;
		logic [FanW-1:0]  edf_max_us;
		logic [StepW-1:0] edf_step;
	} cfg_t;

	typedef struct packed {
		logic [AxisW-1:0] axis_left;
		logic [AxisW-1:0] axis_fan;
		logic [AxisW-1:0] axis_right;
		logic [AxisW-1:0] axis_gantry;
		logic             btn_enable;
		logic             btn_fan;
		logic             btn_kill;
		logic             btn_extrude;
		logic             link_ok;
	} pkt_t;

	typedef struct packed {
		logic            zero;
		logic            neg;
		logic [PwmW-1:0] mag;
	} axis_cmd_t;

	typedef struct packed {
		logic [PinW-1:0] pins;
		logic [PwmW-1:0] pwm;
	} bridge_t;

	function automatic bridge_t to_bridge(axis_cmd_t c, logic invert);
		bridge_t b;
		if (c.zero) begin
			b.pins = PIN_BRAKE;
			b.pwm  = '0;
		end else begin
			b.pins = (c.neg ^ invert) ? PIN_BACK : PIN_FWD;
			b.pwm  = c.mag;
		end
		return b;
	endfunction

endpackage

@@ sv/jmcm_cfg.sv @@
// Configuration register file for the joystick motor command mixer.
// Depends on jmcm_pkg.
module jmcm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [jmcm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [jmcm_pkg::CfgDataW-1:0] cfg_data,
	output jmcm_pkg::cfg_t                cfg
);

	jmcm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone   <= jmcm_pkg::DEADZONE_RST;
			cfg_q.edf_min_us <= jmcm_pkg::EDF_MIN_RST;
			cfg_q.edf_max_us <= jmcm_pkg::EDF_MAX_RST;
			cfg_q.edf_step   <= jmcm_pkg::EDF_STEP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				jmcm_pkg::CFG_DEADZONE: cfg_q.deadzone   <= cfg_data[jmcm_pkg::DzW-1:0];
				jmcm_pkg::CFG_EDF_MIN:  cfg_q.edf_min_us <= cfg_data[jmcm_pkg::FanW-1:0];
				jmcm_pkg::CFG_EDF_MAX:  cfg_q.edf_max_us <= cfg_data[jmcm_pkg::FanW-1:0];
				jmcm_pkg::CFG_EDF_STEP: cfg_q.edf_step   <= cfg_data[jmcm_pkg::StepW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/jmcm_axis.sv @@
// Maps one raw 12-bit stick sample to a signed command with deadzone.
// Depends on jmcm_pkg.
module jmcm_axis (
	input  logic [jmcm_pkg::AxisW-1:0] raw,
	input  logic [jmcm_pkg::DzW-1:0]   deadzone,
	output jmcm_pkg::axis_cmd_t        cmd
);

	logic [17:0] scaled;
	logic [35:0] prod;
	logic [8:0]  quot;
	logic [8:0]  mag9;
	logic        neg;

	always_comb begin
		scaled = {6'b0, raw} * {12'b0, jmcm_pkg::AXIS_MUL};
		// exact floor(scaled / 273) over the whole input range
		prod   = {18'b0, scaled} * {18'b0, jmcm_pkg::AXIS_RECIP};
		quot   = prod[jmcm_pkg::RecipShift+8:jmcm_pkg::RecipShift];
		neg    = quot < jmcm_pkg::AXIS_CENTER;
		mag9   = neg ? (jmcm_pkg::AXIS_CENTER - quot) : (quot - jmcm_pkg::AXIS_CENTER);
		cmd.neg  = neg;
		cmd.mag  = mag9[jmcm_pkg::PwmW-1:0];
		cmd.zero = (mag9[jmcm_pkg::PwmW-1:0] < deadzone) || (mag9 == 9'd0);
	end

endmodule

@@ sv/jmcm_state.sv @@
// Kill latch, fan width and held bridge state, plus the result register.
// Depends on jmcm_pkg; fed by the axis mappers and the input stage.
module jmcm_state (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        out_ready,
	input  jmcm_pkg::pkt_t              pkt_s1,
	input  jmcm_pkg::cfg_t              cfg,
	input  jmcm_pkg::axis_cmd_t         cmd_left,
	input  jmcm_pkg::axis_cmd_t         cmd_ext,
	input  jmcm_pkg::axis_cmd_t         cmd_right,
	input  jmcm_pkg::axis_cmd_t         cmd_gantry,
	output logic                        out_valid,
	output logic [jmcm_pkg::PinW-1:0]   left_pins,
	output logic [jmcm_pkg::PwmW-1:0]   left_pwm,
	output logic [jmcm_pkg::PinW-1:0]   right_pins,
	output logic [jmcm_pkg::PwmW-1:0]   right_pwm,
	output logic [jmcm_pkg::PinW-1:0]   gantry_pins,
	output logic [jmcm_pkg::PwmW-1:0]   gantry_pwm,
	output logic [jmcm_pkg::PinW-1:0]   ext_pins,
	output logic [jmcm_pkg::PwmW-1:0]   ext_pwm,
	output logic [jmcm_pkg::FanW-1:0]   fan_pulse_us,
	output logic                        killed
);

	logic                       kill_q;
	logic [jmcm_pkg::FanW-1:0]  fan_width_q;
	logic [jmcm_pkg::PinW-1:0]  gantry_hold_q;
	logic [jmcm_pkg::PinW-1:0]  ext_pin_q;
	logic [jmcm_pkg::PwmW-1:0]  ext_pwm_q;
	logic                       out_valid_q;

	logic                       kill_d;
	logic                       stop;
	logic signed [12:0]         inc;
	logic signed [12:0]         width_sum;
	logic [jmcm_pkg::FanW-1:0]  fan_d;
	logic [jmcm_pkg::PinW-1:0]  gantry_hold_d;
	logic [jmcm_pkg::PinW-1:0]  ext_pin_d;
	logic [jmcm_pkg::PwmW-1:0]  ext_pwm_d;
	jmcm_pkg::bridge_t          br_left;
	jmcm_pkg::bridge_t          br_right;
	jmcm_pkg::bridge_t          br_gantry;
	jmcm_pkg::bridge_t          br_ext;
	jmcm_pkg::bridge_t          lo_d;
	jmcm_pkg::bridge_t          ro_d;
	logic [jmcm_pkg::PwmW-1:0]  go_pwm_d;

	always_comb begin
		// enable wins over kill
		if (!pkt_s1.btn_enable)
			kill_d = 1'b0;
		else if (!pkt_s1.btn_kill)
			kill_d = 1'b1;
		else
			kill_d = kill_q;
		stop = kill_d || !pkt_s1.link_ok;

		if (pkt_s1.axis_fan < jmcm_pkg::FAN_UP_BELOW)
			inc = $signed({7'b0, cfg.edf_step});
		else if (pkt_s1.axis_fan == jmcm_pkg::FAN_DOWN_AT)
			inc = -$signed({7'b0, cfg.edf_step});
		else
			inc = '0;
		width_sum = $signed({2'b0, fan_width_q}) + inc;

		br_left   = jmcm_pkg::to_bridge(cmd_left, 1'b1);
		br_right  = jmcm_pkg::to_bridge(cmd_right, 1'b1);
		br_gantry = jmcm_pkg::to_bridge(cmd_gantry, 1'b1);
		br_ext    = jmcm_pkg::to_bridge(cmd_ext, 1'b0);

		fan_d         = fan_width_q;
		gantry_hold_d = gantry_hold_q;
		ext_pin_d     = ext_pin_q;
		ext_pwm_d     = ext_pwm_q;
		lo_d          = br_left;
		ro_d          = br_right;
		go_pwm_d      = br_gantry.pwm;

		if (stop) begin
			fan_d     = cfg.edf_min_us;
			lo_d      = '{pins: jmcm_pkg::PIN_BRAKE, pwm: '0};
			ro_d      = '{pins: jmcm_pkg::PIN_BRAKE, pwm: '0};
			go_pwm_d  = '0;
			ext_pin_d = jmcm_pkg::PIN_BRAKE;
			ext_pwm_d = '0;
		end else begin
			if (!pkt_s1.btn_fan) begin
				if (width_sum < $signed({2'b0, cfg.edf_min_us}))
					fan_d = cfg.edf_min_us;
				else if (width_sum > $signed({2'b0, cfg.edf_max_us}))
					fan_d = cfg.edf_max_us;
				else
					fan_d = width_sum[jmcm_pkg::FanW-1:0];
			end else if (!pkt_s1.btn_extrude) begin
				ext_pin_d = br_ext.pins;
				ext_pwm_d = br_ext.pwm;
			end
			gantry_hold_d = br_gantry.pins;
		end

		// released extruder button always brakes
		if (pkt_s1.btn_extrude) begin
			ext_pin_d = jmcm_pkg::PIN_BRAKE;
			ext_pwm_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kill_q        <= 1'b0;
			fan_width_q   <= jmcm_pkg::EDF_MIN_RST;
			gantry_hold_q <= jmcm_pkg::PIN_BRAKE;
			ext_pin_q     <= jmcm_pkg::PIN_BRAKE;
			ext_pwm_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				kill_q        <= kill_d;
				fan_width_q   <= fan_d;
				gantry_hold_q <= gantry_hold_d;
				ext_pin_q     <= ext_pin_d;
				ext_pwm_q     <= ext_pwm_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// result payload, loaded on each advance
	always_ff @(posedge clk) begin
		if (advance) begin
			left_pins    <= lo_d.pins;
			left_pwm     <= lo_d.pwm;
			right_pins   <= ro_d.pins;
			right_pwm    <= ro_d.pwm;
			gantry_pins  <= gantry_hold_d;
			gantry_pwm   <= go_pwm_d;
			ext_pins     <= ext_pin_d;
			ext_pwm      <= ext_pwm_d;
			fan_pulse_us <= fan_d;
			killed       <= kill_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/joystick_motor_command_mixer.sv @@
// Joystick motor command mixer, top level.
// Result path: input register, then result register, which loads once it is free or being drained.
// Throughput: one packet per cycle while out_ready holds; the input register refills while a result waits.
// Reset (arst_n low, asynchronous): registers to defaults, kill latch clear,
// fan width 1100, held gantry and extruder pins brake, no items in flight.
// Depends on jmcm_pkg, jmcm_cfg, jmcm_axis, jmcm_state.
module joystick_motor_command_mixer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [jmcm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [jmcm_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [jmcm_pkg::AxisW-1:0]    axis_left,
	input  logic [jmcm_pkg::AxisW-1:0]    axis_fan,
	input  logic [jmcm_pkg::AxisW-1:0]    axis_right,
	input  logic [jmcm_pkg::AxisW-1:0]    axis_gantry,
	input  logic                          btn_enable,
	input  logic                          btn_fan,
	input  logic                          btn_kill,
	input  logic                          btn_extrude,
	input  logic                          link_ok,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [jmcm_pkg::PinW-1:0]     left_pins,
	output logic [jmcm_pkg::PwmW-1:0]     left_pwm,
	output logic [jmcm_pkg::PinW-1:0]     right_pins,
	output logic [jmcm_pkg::PwmW-1:0]     right_pwm,
	output logic [jmcm_pkg::PinW-1:0]     gantry_pins,
	output logic [jmcm_pkg::PwmW-1:0]     gantry_pwm,
	output logic [jmcm_pkg::PinW-1:0]     ext_pins,
	output logic [jmcm_pkg::PwmW-1:0]     ext_pwm,
	output logic [jmcm_pkg::FanW-1:0]     fan_pulse_us,
	output logic                          killed
);

	jmcm_pkg::cfg_t      cfg;
	jmcm_pkg::pkt_t      pkt_s1;
	logic                valid_s1;
	logic                advance;
	jmcm_pkg::axis_cmd_t cmd_left;
	jmcm_pkg::axis_cmd_t cmd_ext;
	jmcm_pkg::axis_cmd_t cmd_right;
	jmcm_pkg::axis_cmd_t cmd_gantry;

	// move stage 1 into the result register when it is free or being drained
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pkt_s1.axis_left   <= axis_left;
			pkt_s1.axis_fan    <= axis_fan;
			pkt_s1.axis_right  <= axis_right;
			pkt_s1.axis_gantry <= axis_gantry;
			pkt_s1.btn_enable  <= btn_enable;
			pkt_s1.btn_fan     <= btn_fan;
			pkt_s1.btn_kill    <= btn_kill;
			pkt_s1.btn_extrude <= btn_extrude;
			pkt_s1.link_ok     <= link_ok;
		end
	end

	jmcm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jmcm_axis u_axis_left (
		.raw      (pkt_s1.axis_left),
		.deadzone (cfg.deadzone),
		.cmd      (cmd_left)
	);

	jmcm_axis u_axis_ext (
		.raw      (pkt_s1.axis_fan),
		.deadzone (cfg.deadzone),
		.cmd      (cmd_ext)
	);

	jmcm_axis u_axis_right (
		.raw      (pkt_s1.axis_right),
		.deadzone (cfg.deadzone),
		.cmd      (cmd_right)
	);

	jmcm_axis u_axis_gantry (
		.raw      (pkt_s1.axis_gantry),
		.deadzone (cfg.deadzone),
		.cmd      (cmd_gantry)
	);

	jmcm_state u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.out_ready    (out_ready),
		.pkt_s1       (pkt_s1),
		.cfg          (cfg),
		.cmd_left     (cmd_left),
		.cmd_ext      (cmd_ext),
		.cmd_right    (cmd_right),
		.cmd_gantry   (cmd_gantry),
		.out_valid    (out_valid),
		.left_pins    (left_pins),
		.left_pwm     (left_pwm),
		.right_pins   (right_pins),
		.right_pwm    (right_pwm),
		.gantry_pins  (gantry_pins),
		.gantry_pwm   (gantry_pwm),
		.ext_pins     (ext_pins),
		.ext_pwm      (ext_pwm),
		.fan_pulse_us (fan_pulse_us),
		.killed       (killed)
	);

endmodule

@@ sv/jmcm_checker.sv @@
// Port-level checks for the joystick motor command mixer, bound to the top level.
// Depends on jmcm_pkg and joystick_motor_command_mixer.
module jmcm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [jmcm_pkg::PinW-1:0]     left_pins,
	input logic [jmcm_pkg::PwmW-1:0]     left_pwm,
	input logic [jmcm_pkg::PinW-1:0]     right_pins,
	input logic [jmcm_pkg::PwmW-1:0]     right_pwm,
	input logic [jmcm_pkg::PinW-1:0]     gantry_pins,
	input logic [jmcm_pkg::PwmW-1:0]     gantry_pwm,
	input logic [jmcm_pkg::PinW-1:0]     ext_pins,
	input logic [jmcm_pkg::PwmW-1:0]     ext_pwm,
	input logic [jmcm_pkg::FanW-1:0]     fan_pulse_us,
	input logic                          killed
);

	// a stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_pwm) && $stable(right_pwm)
			&& $stable(gantry_pwm) && $stable(ext_pwm) && $stable(fan_pulse_us)
			&& $stable(killed) && $stable(ext_pins) && $stable(gantry_pins))
		else $error("result changed while stalled");

	a_kill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && killed |-> left_pwm == '0 && right_pwm == '0
			&& gantry_pwm == '0 && ext_pwm == '0)
		else $error("duty nonzero while killed");

	a_drive_brake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((left_pwm == '0) == (left_pins == jmcm_pkg::PIN_BRAKE))
			&& ((right_pwm == '0) == (right_pins == jmcm_pkg::PIN_BRAKE)))
		else $error("drive pins and duty disagree");

	a_ext_brake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((ext_pwm == '0) == (ext_pins == jmcm_pkg::PIN_BRAKE))
			&& gantry_pins != '0)
		else $error("extruder or gantry pin state invalid");

endmodule

bind joystick_motor_command_mixer jmcm_checker u_jmcm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.left_pins    (left_pins),
	.left_pwm     (left_pwm),
	.right_pins   (right_pins),
	.right_pwm    (right_pwm),
	.gantry_pins  (gantry_pins),
	.gantry_pwm   (gantry_pwm),
	.ext_pins     (ext_pins),
	.ext_pwm      (ext_pwm),
	.fan_pulse_us (fan_pulse_us),
	.killed       (killed)
);

@@ dv/joystick_motor_command_mixer_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for joystick_motor_command_mixer: random and directed packets,
// register changes between phases, a scoreboard that predicts each command set.
// Depends on jmcm_pkg and the mixer RTL.
module joystick_motor_command_mixer_tb;

	localparam bit PRESS = 1'b0;
	localparam bit FREE  = 1'b1;

	typedef struct packed {
		logic [jmcm_pkg::PinW-1:0] left_pins;
		logic [jmcm_pkg::PwmW-1:0] left_pwm;
		logic [jmcm_pkg::PinW-1:0] right_pins;
		logic [jmcm_pkg::PwmW-1:0] right_pwm;
		logic [jmcm_pkg::PinW-1:0] gantry_pins;
		logic [jmcm_pkg::PwmW-1:0] gantry_pwm;
		logic [jmcm_pkg::PinW-1:0] ext_pins;
		logic [jmcm_pkg::PwmW-1:0] ext_pwm;
		logic [jmcm_pkg::FanW-1:0] fan_pulse_us;
		logic                      killed;
	} motor_cmd_t;

	class command_scoreboard;
		logic [jmcm_pkg::DzW-1:0]   dz_q;
		logic [jmcm_pkg::FanW-1:0]  min_q;
		logic [jmcm_pkg::FanW-1:0]  max_q;
		logic [jmcm_pkg::StepW-1:0] step_q;
		bit                         kill_q;
		logic [jmcm_pkg::FanW-1:0]  fan_q;
		logic [jmcm_pkg::PinW-1:0]  gantry_pins_q;
		logic [jmcm_pkg::PinW-1:0]  ext_pins_q;
		logic [jmcm_pkg::PwmW-1:0]  ext_pwm_q;
		motor_cmd_t                 pending_cmds[$];
		int                         faults;
		int                         checked;

		function new();
			dz_q          = 8'd100;
			min_q         = 11'd1100;
			max_q         = 11'd1900;
			step_q        = 6'd3;
			kill_q        = 1'b0;
			fan_q         = 11'd1100;
			gantry_pins_q = jmcm_pkg::PIN_BRAKE;
			ext_pins_q    = jmcm_pkg::PIN_BRAKE;
			ext_pwm_q     = '0;
			faults        = 0;
			checked       = 0;
		endfunction

		function void set_reg(logic [jmcm_pkg::CfgIdxW-1:0] idx,
				logic [jmcm_pkg::CfgDataW-1:0] data);
			case (idx)
				jmcm_pkg::CFG_DEADZONE: dz_q   = data[jmcm_pkg::DzW-1:0];
				jmcm_pkg::CFG_EDF_MIN:  min_q  = data[jmcm_pkg::FanW-1:0];
				jmcm_pkg::CFG_EDF_MAX:  max_q  = data[jmcm_pkg::FanW-1:0];
				jmcm_pkg::CFG_EDF_STEP: step_q = data[jmcm_pkg::StepW-1:0];
				default: ;
			endcase
		endfunction

		// Scale raw 0..4095 to -255..255, then zero inside the deadzone
		function int axis_cmd(logic [jmcm_pkg::AxisW-1:0] raw);
			int x;
			int v;
			int mag;
			x = int'(raw);
			v = (x * 510) / 4095 - 255;
			mag = (v < 0) ? -v : v;
			if (mag < int'(dz_q))
				v = 0;
			return v;
		endfunction

		function void h_bridge(int v, output logic [jmcm_pkg::PinW-1:0] pins,
				output logic [jmcm_pkg::PwmW-1:0] pwm);
			if (v == 0) begin
				pins = jmcm_pkg::PIN_BRAKE;
				pwm  = '0;
			end else if (v < 0) begin
				pins = jmcm_pkg::PIN_BACK;
				pwm  = jmcm_pkg::PwmW'(-v);
			end else begin
				pins = jmcm_pkg::PIN_FWD;
				pwm  = jmcm_pkg::PwmW'(v);
			end
		endfunction

		function void note_packet(jmcm_pkg::pkt_t p);
			motor_cmd_t r;
			int left_v;
			int ext_v;
			int right_v;
			int gantry_v;
			int inc;
			int w;
			left_v   = -axis_cmd(p.axis_left);
			ext_v    = axis_cmd(p.axis_fan);
			right_v  = -axis_cmd(p.axis_right);
			gantry_v = -axis_cmd(p.axis_gantry);
			inc = 0;
			if (p.axis_fan < jmcm_pkg::FAN_UP_BELOW)
				inc = int'(step_q);
			else if (p.axis_fan == jmcm_pkg::FAN_DOWN_AT)
				inc = -int'(step_q);
			// enable wins over kill
			if (p.btn_enable == PRESS)
				kill_q = 1'b0;
			else if (p.btn_kill == PRESS)
				kill_q = 1'b1;
			r = '0;
			if (kill_q || !p.link_ok) begin
				fan_q        = min_q;
				r.left_pins  = jmcm_pkg::PIN_BRAKE;
				r.right_pins = jmcm_pkg::PIN_BRAKE;
				ext_pins_q   = jmcm_pkg::PIN_BRAKE;
				ext_pwm_q    = '0;
			end else begin
				if (p.btn_fan == PRESS) begin
					w = int'(fan_q) + inc;
					if (w < int'(min_q))
						w = int'(min_q);
					else if (w > int'(max_q))
						w = int'(max_q);
					fan_q = jmcm_pkg::FanW'(w);
				end else if (p.btn_extrude == PRESS) begin
					h_bridge(ext_v, ext_pins_q, ext_pwm_q);
				end
				h_bridge(left_v, r.left_pins, r.left_pwm);
				h_bridge(right_v, r.right_pins, r.right_pwm);
				h_bridge(gantry_v, gantry_pins_q, r.gantry_pwm);
			end
			if (p.btn_extrude == FREE) begin
				ext_pins_q = jmcm_pkg::PIN_BRAKE;
				ext_pwm_q  = '0;
			end
			r.gantry_pins  = gantry_pins_q;
			r.ext_pins     = ext_pins_q;
			r.ext_pwm      = ext_pwm_q;
			r.fan_pulse_us = fan_q;
			r.killed       = kill_q;
			pending_cmds.push_back(r);
		endfunction

		function string show(motor_cmd_t c);
			return $sformatf("L %0d/%0d R %0d/%0d G %0d/%0d E %0d/%0d fan %0d kill %0d",
				c.left_pins, c.left_pwm, c.right_pins, c.right_pwm, c.gantry_pins,
				c.gantry_pwm, c.ext_pins, c.ext_pwm, c.fan_pulse_us, c.killed);
		endfunction

		function void check_result(motor_cmd_t got);
			motor_cmd_t want;
			checked++;
			if (pending_cmds.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("result %0d arrived with nothing pending: %s", checked, show(got));
				return;
			end
			want = pending_cmds.pop_front();
			if (got !== want) begin
				faults++;
				if (faults <= 10)
					$display("result %0d mismatch\n  exp %s\n  got %s", checked,
						show(want), show(got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [jmcm_pkg::CfgIdxW-1:0] cfg_index;
	logic [jmcm_pkg::CfgDataW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	jmcm_pkg::pkt_t pkt_q;
	logic out_valid;
	logic out_ready;
	logic [jmcm_pkg::PinW-1:0] left_pins;
	logic [jmcm_pkg::PwmW-1:0] left_pwm;
	logic [jmcm_pkg::PinW-1:0] right_pins;
	logic [jmcm_pkg::PwmW-1:0] right_pwm;
	logic [jmcm_pkg::PinW-1:0] gantry_pins;
	logic [jmcm_pkg::PwmW-1:0] gantry_pwm;
	logic [jmcm_pkg::PinW-1:0] ext_pins;
	logic [jmcm_pkg::PwmW-1:0] ext_pwm;
	logic [jmcm_pkg::FanW-1:0] fan_pulse_us;
	logic killed;

	command_scoreboard sb = new();
	bit calm = 1'b0;
	int send_idle_pct = 20;

	joystick_motor_command_mixer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.axis_left    (pkt_q.axis_left),
		.axis_fan     (pkt_q.axis_fan),
		.axis_right   (pkt_q.axis_right),
		.axis_gantry  (pkt_q.axis_gantry),
		.btn_enable   (pkt_q.btn_enable),
		.btn_fan      (pkt_q.btn_fan),
		.btn_kill     (pkt_q.btn_kill),
		.btn_extrude  (pkt_q.btn_extrude),
		.link_ok      (pkt_q.link_ok),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_pins    (left_pins),
		.left_pwm     (left_pwm),
		.right_pins   (right_pins),
		.right_pwm    (right_pwm),
		.gantry_pins  (gantry_pins),
		.gantry_pwm   (gantry_pwm),
		.ext_pins     (ext_pins),
		.ext_pwm      (ext_pwm),
		.fan_pulse_us (fan_pulse_us),
		.killed       (killed)
	);

	always #10 clk = ~clk;

	function automatic jmcm_pkg::pkt_t stick_packet(int al, int af, int ar, int ag,
			bit en, bit fan, bit kill, bit ext, bit link);
		jmcm_pkg::pkt_t p;
		p.axis_left   = jmcm_pkg::AxisW'(al);
		p.axis_fan    = jmcm_pkg::AxisW'(af);
		p.axis_right  = jmcm_pkg::AxisW'(ar);
		p.axis_gantry = jmcm_pkg::AxisW'(ag);
		p.btn_enable  = en;
		p.btn_fan     = fan;
		p.btn_kill    = kill;
		p.btn_extrude = ext;
		p.link_ok     = link;
		return p;
	endfunction

	function automatic logic [jmcm_pkg::AxisW-1:0] drive_axis();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return jmcm_pkg::AxisW'($urandom_range(1100, 3000));
			default: return jmcm_pkg::AxisW'($urandom);
		endcase
	endfunction

	function automatic jmcm_pkg::pkt_t random_packet();
		jmcm_pkg::pkt_t p;
		p.axis_left   = drive_axis();
		p.axis_right  = drive_axis();
		p.axis_gantry = drive_axis();
		// bias the fan stick toward the step zones
		case ($urandom_range(5))
			0, 1: p.axis_fan = jmcm_pkg::AxisW'($urandom_range(0, 174));
			2: p.axis_fan = jmcm_pkg::FAN_DOWN_AT;
			3: p.axis_fan = jmcm_pkg::FAN_UP_BELOW;
			default: p.axis_fan = jmcm_pkg::AxisW'($urandom);
		endcase
		p.btn_enable  = ($urandom_range(99) >= 15);
		p.btn_fan     = ($urandom_range(99) >= 40);
		p.btn_kill    = ($urandom_range(99) >= 6);
		p.btn_extrude = ($urandom_range(99) >= 50);
		p.link_ok     = ($urandom_range(99) >= 4);
		return p;
	endfunction

	// Hold valid and payload until the transfer completes
	task automatic send_packet(input jmcm_pkg::pkt_t p);
		int gap;
		if (!calm && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pkt_q    <= p;
		do @(posedge clk); while (!in_ready);
		sb.note_packet(p);
	endtask

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0)
				send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
			send_packet(random_packet());
		end
	endtask

	// Drop valid and wait for every pending command set
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_cmds.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_regs(input logic [jmcm_pkg::CfgDataW-1:0] dz,
			input logic [jmcm_pkg::CfgDataW-1:0] lo,
			input logic [jmcm_pkg::CfgDataW-1:0] hi,
			input logic [jmcm_pkg::CfgDataW-1:0] st);
		logic [jmcm_pkg::CfgIdxW-1:0] idx [4];
		logic [jmcm_pkg::CfgDataW-1:0] vals [4];
		idx  = '{jmcm_pkg::CFG_DEADZONE, jmcm_pkg::CFG_EDF_MIN, jmcm_pkg::CFG_EDF_MAX,
			jmcm_pkg::CFG_EDF_STEP};
		vals = '{dz, lo, hi, st};
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.set_reg(idx[i], vals[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : result_sink
		int stall;
		int pct;
		int cyc;
		motor_cmd_t got;
		stall = 0;
		pct   = 0;
		cyc   = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (out_valid && out_ready) begin
				got = '{left_pins: left_pins, left_pwm: left_pwm, right_pins: right_pins,
					right_pwm: right_pwm, gantry_pins: gantry_pins, gantry_pwm: gantry_pwm,
					ext_pins: ext_pins, ext_pwm: ext_pwm, fan_pulse_us: fan_pulse_us,
					killed: killed};
				sb.check_result(got);
				// long hold-off so the sender backs up into the block
				if (sb.checked == 200)
					stall = 150;
			end
			if (cyc % 64 == 0)
				pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 40);
			if (stall == 0 && !calm && $urandom_range(99) < pct)
				stall = $urandom_range(1, 11);
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= jmcm_pkg::CFG_DEADZONE;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		pkt_q     <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, deadzone edges, fan steps, kill and link handling
		send_packet(stick_packet(2048, 2048, 2048, 2048, FREE, FREE, FREE, FREE, 1));
		send_packet(stick_packet(0, 0, 4095, 0, FREE, FREE, FREE, PRESS, 1));
		send_packet(stick_packet(4095, 4095, 0, 4095, FREE, FREE, FREE, PRESS, 1));
		send_packet(stick_packet(1245, 1253, 2850, 2851, FREE, FREE, FREE, PRESS, 1));
		send_packet(stick_packet(2048, 1245, 2048, 4095, FREE, PRESS, FREE, PRESS, 1));
		send_packet(stick_packet(2048, 0, 2048, 0, FREE, PRESS, FREE, FREE, 1));
		send_packet(stick_packet(2048, 174, 2048, 0, FREE, PRESS, FREE, FREE, 1));
		send_packet(stick_packet(2048, 175, 2048, 0, FREE, PRESS, FREE, FREE, 1));
		send_packet(stick_packet(2048, 4095, 2048, 0, FREE, PRESS, FREE, FREE, 1));
		send_packet(stick_packet(2048, 4094, 2048, 0, FREE, PRESS, FREE, FREE, 1));
		send_packet(stick_packet(0, 0, 4095, 4095, FREE, FREE, PRESS, FREE, 1));
		send_packet(stick_packet(4095, 4095, 4095, 4095, FREE, FREE, FREE, PRESS, 1));
		send_packet(stick_packet(0, 0, 0, 0, PRESS, FREE, PRESS, FREE, 1));
		send_packet(stick_packet(0, 0, 0, 0, FREE, FREE, FREE, PRESS, 0));
		send_packet(stick_packet(0, 0, 0, 0, FREE, FREE, FREE, PRESS, 1));
		send_packet(stick_packet(4095, 4095, 4095, 4095, PRESS, PRESS, FREE, FREE, 1));

		run_random(400);
		settle();

		// widest limits, no deadzone, largest step
		program_regs(11'd0, 11'd0, 11'd2047, 11'd63);
		run_random(300);
		settle();

		// crossed limits, full deadzone, no step; upper data bits set
		program_regs(11'h7FF, 11'd2047, 11'd0, 11'h7C0);
		run_random(250);
		settle();

		for (int k = 0; k < 3; k++) begin
			program_regs(jmcm_pkg::CfgDataW'($urandom), jmcm_pkg::CfgDataW'($urandom),
				jmcm_pkg::CfgDataW'($urandom), jmcm_pkg::CfgDataW'($urandom));
			run_random(150);
			settle();
		end

		program_regs(11'd100, 11'd1100, 11'd1900, 11'd3);
		calm = 1'b1;
		run_random(300);

		in_valid <= 1'b0;
		while (sb.pending_cmds.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.faults == 0 && sb.pending_cmds.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
